// ===== rtl/sm4_pkg.sv =====
// sm4_pkg: constants, state type, s-box table and round functions of the sm4 round engine
// no dependencies; used by the channel interfaces and sm4_block_cipher_rounds

package sm4_pkg;

	localparam int ROUNDS   = 32;
	localparam int RND_W    = $clog2(ROUNDS);
	localparam int KEY_SETS = 2;
	localparam int KEY_DEPTH = KEY_SETS * ROUNDS;
	localparam int KADDR_W  = $clog2(KEY_DEPTH);
	localparam int WORD_W   = 32;
	localparam int HALF_W   = 64;

	localparam logic CMD_KEY_WRITE = 1'b0;
	localparam logic CMD_CRYPT     = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} sm4_state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
		rotl = (v << n) | (v >> (WORD_W - n));
	endfunction

	// linear diffusion map
	function automatic logic [WORD_W-1:0] lin_map(input logic [WORD_W-1:0] b);
		lin_map = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	// byte-wise s-box then linear map
	function automatic logic [WORD_W-1:0] tau_l(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] s;
		s = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
		tau_l = lin_map(s);
	endfunction

endpackage

// ===== rtl/sm4_if.sv =====
// sm4_in_if, sm4_out_if: valid/ready channels carrying command beats and result beats
// depends on sm4_pkg for field widths

interface sm4_in_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic                          key_set;
	logic [sm4_pkg::RND_W-1:0]     key_index;
	logic [sm4_pkg::WORD_W-1:0]    key_value;
	logic [sm4_pkg::HALF_W-1:0]    block_high;
	logic [sm4_pkg::HALF_W-1:0]    block_low;

	modport source (
		output valid, command, key_set, key_index, key_value, block_high, block_low,
		input  ready
	);
	modport sink (
		input  valid, command, key_set, key_index, key_value, block_high, block_low,
		output ready
	);
endinterface

interface sm4_out_if;
	logic                          valid;
	logic                          ready;
	logic [sm4_pkg::HALF_W-1:0]    out_high;
	logic [sm4_pkg::HALF_W-1:0]    out_low;

	modport source (
		output valid, out_high, out_low,
		input  ready
	);
	modport sink (
		input  valid, out_high, out_low,
		output ready
	);
endinterface

// ===== rtl/sm4_block_cipher_rounds.sv =====
// sm4_block_cipher_rounds: sm4 round engine with a 64-entry round key memory
// depends on sm4_pkg and the channel interfaces in sm4_if.sv

// A key-write beat stores one 32-bit round key into set 0 (encrypt) or set 1
// (decrypt); the block stays ready for the next beat. A crypt beat takes the
// block and runs 32 rounds on one shared round unit (s-box plus linear map),
// one round per cycle except that the last round waits for room in the output
// register; the engine is not ready while the rounds run, and the next beat is
// taken once it is back in idle after the last round. The round key for each
// round is fetched into a register from the key memory ahead of that round.
// The result waits in an output register, so the next beat is taken while it
// is pending; a second block finishing before the first result is taken holds
// in its last round.
// Every key of the selected set must be written before a crypt beat uses it.

module sm4_block_cipher_rounds (
	input  logic         clk,
	input  logic         arst_n,
	sm4_in_if.sink       cmd,
	sm4_out_if.source    result
);

	sm4_pkg::sm4_state_t              state_q, state_d;
	logic [sm4_pkg::RND_W-1:0]        cnt_q;
	logic                             set_q;
	logic [sm4_pkg::WORD_W-1:0]       x0_q, x1_q, x2_q, x3_q;
	logic [sm4_pkg::WORD_W-1:0]       rk_q;
	logic [sm4_pkg::WORD_W-1:0]       key_mem_q [sm4_pkg::KEY_DEPTH];
	logic [sm4_pkg::HALF_W-1:0]       res_high_q, res_low_q;
	logic                             res_valid_q;

	logic                             accept;
	logic                             last;
	logic                             out_free;
	logic                             adv;
	logic                             rk_en;
	logic [sm4_pkg::KADDR_W-1:0]      rd_addr;
	logic [sm4_pkg::WORD_W-1:0]       nw;

	assign accept   = cmd.valid && cmd.ready;
	assign last     = (cnt_q == sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1));
	assign out_free = !res_valid_q || result.ready;
	assign nw       = x0_q ^ sm4_pkg::tau_l(x1_q ^ x2_q ^ x3_q ^ rk_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm4_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		adv       = 1'b0;
		unique case (state_q)
			sm4_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid && cmd.command == sm4_pkg::CMD_CRYPT) begin
					state_d = sm4_pkg::ST_RUN;
				end
			end
			sm4_pkg::ST_RUN: begin
				// last round waits for room in the output register
				adv = !last || out_free;
				if (last && out_free) begin
					state_d = sm4_pkg::ST_IDLE;
				end
			end
			default: state_d = sm4_pkg::ST_IDLE;
		endcase
	end

	// key for the next round is fetched into rk_q ahead of that round
	assign rk_en   = (state_q == sm4_pkg::ST_IDLE) || adv;
	assign rd_addr = (state_q == sm4_pkg::ST_IDLE) ?
		{cmd.key_set, sm4_pkg::RND_W'(0)} :
		{set_q, sm4_pkg::RND_W'(cnt_q + 1'b1)};

	always_ff @(posedge clk) begin
		if (accept && cmd.command == sm4_pkg::CMD_KEY_WRITE) begin
			key_mem_q[{cmd.key_set, cmd.key_index}] <= cmd.key_value;
		end
		if (rk_en) begin
			rk_q <= key_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			set_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= '0;
			set_q <= cmd.key_set;
		end else if (adv) begin
			cnt_q <= sm4_pkg::RND_W'(cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q <= cmd.block_high[63:32];
			x1_q <= cmd.block_high[31:0];
			x2_q <= cmd.block_low[63:32];
			x3_q <= cmd.block_low[31:0];
		end else if (adv) begin
			x0_q <= x1_q;
			x1_q <= x2_q;
			x2_q <= x3_q;
			x3_q <= nw;
		end
	end

	// final words leave in reversed order
	always_ff @(posedge clk) begin
		if (adv && last) begin
			res_high_q <= {nw, x3_q};
			res_low_q  <= {x2_q, x1_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.out_high = res_high_q;
	assign result.out_low  = res_low_q;

endmodule

// ===== tb/sv/sm4_round_checker.sv =====
// sm4_round_checker: watches the command and result channels of the sm4 round engine
// depends on sm4_pkg and the channel interfaces; predicts each block and compares results

module sm4_round_checker (
	input  logic  clk,
	input  logic  arst_n,
	sm4_in_if     cmd,
	sm4_out_if    result,
	output int    mismatch_count,
	output int    blocks_in_flight
);

	typedef struct packed {
		logic [sm4_pkg::HALF_W-1:0] hi;
		logic [sm4_pkg::HALF_W-1:0] lo;
	} cipher_block_t;

	localparam logic [7:0] SUB_BYTE [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	logic [sm4_pkg::WORD_W-1:0] round_keys [2][sm4_pkg::ROUNDS];
	cipher_block_t              awaited_blocks [$];

	// s-box on every byte, then the linear diffusion
	function automatic logic [sm4_pkg::WORD_W-1:0] round_mix(
			input logic [sm4_pkg::WORD_W-1:0] v);
		logic [sm4_pkg::WORD_W-1:0] s;
		s = {SUB_BYTE[v[31:24]], SUB_BYTE[v[23:16]], SUB_BYTE[v[15:8]], SUB_BYTE[v[7:0]]};
		return s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
			^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
	endfunction

	function automatic cipher_block_t run_cipher_rounds(input logic set,
			input logic [sm4_pkg::HALF_W-1:0] hi, input logic [sm4_pkg::HALF_W-1:0] lo);
		logic [sm4_pkg::WORD_W-1:0] w0, w1, w2, w3, nw;
		cipher_block_t              res;
		w0 = hi[63:32];
		w1 = hi[31:0];
		w2 = lo[63:32];
		w3 = lo[31:0];
		for (int r = 0; r < sm4_pkg::ROUNDS; r++) begin
			nw = w0 ^ round_mix(w1 ^ w2 ^ w3 ^ round_keys[set][r]);
			w0 = w1;
			w1 = w2;
			w2 = w3;
			w3 = nw;
		end
		res.hi = {w3, w2};
		res.lo = {w1, w0};
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count   = 0;
		blocks_in_flight = 0;
	end

	always @(posedge clk) begin
		cipher_block_t want;
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				if (cmd.command == sm4_pkg::CMD_CRYPT)
					awaited_blocks.push_back(
						run_cipher_rounds(cmd.key_set, cmd.block_high, cmd.block_low));
				else
					round_keys[cmd.key_set][cmd.key_index] = cmd.key_value;
			end
			if (result.valid && result.ready) begin
				if (awaited_blocks.size() == 0) begin
					flag_mismatch($sformatf("unexpected result %h %h",
						result.out_high, result.out_low));
				end else begin
					want = awaited_blocks.pop_front();
					if (result.out_high !== want.hi)
						flag_mismatch($sformatf("out_high got %h want %h",
							result.out_high, want.hi));
					if (result.out_low !== want.lo)
						flag_mismatch($sformatf("out_low got %h want %h",
							result.out_low, want.lo));
				end
			end
			blocks_in_flight = awaited_blocks.size();
		end
	end

endmodule

// ===== tb/sv/tb_sm4_block_cipher_rounds.sv =====
// tb_sm4_block_cipher_rounds: stimulus, receiver stalls and verdict for the sm4 round engine
// depends on sm4_pkg, the channel interfaces, sm4_block_cipher_rounds and sm4_round_checker

module tb_sm4_block_cipher_rounds;

	localparam logic KSET_ENC    = 1'b0;
	localparam logic KSET_DEC    = 1'b1;
	localparam int   CYCLE_LIMIT = 1000000;
	localparam int   HOLD_AT     = 250;
	localparam int   HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   blocks_in_flight;
	int   beats_sent;
	int   src_idle_pct;
	int   snk_stall_pct;
	int   cycle_count;

	sm4_in_if  cmd ();
	sm4_out_if result ();

	sm4_block_cipher_rounds dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.result (result)
	);

	sm4_round_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.result           (result),
		.mismatch_count   (mismatch_count),
		.blocks_in_flight (blocks_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the engine backs up
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left    = 0;
		hold_done    = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && beats_sent >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	function automatic logic [sm4_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic offer_beat(input logic command, input logic set,
			input logic [sm4_pkg::RND_W-1:0] idx, input logic [sm4_pkg::WORD_W-1:0] kval,
			input logic [sm4_pkg::HALF_W-1:0] hi, input logic [sm4_pkg::HALF_W-1:0] lo);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			cmd.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		cmd.command    <= command;
		cmd.key_set    <= set;
		cmd.key_index  <= idx;
		cmd.key_value  <= kval;
		cmd.block_high <= hi;
		cmd.block_low  <= lo;
		cmd.valid      <= 1'b1;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic write_key(input logic set, input logic [sm4_pkg::RND_W-1:0] idx,
			input logic [sm4_pkg::WORD_W-1:0] kval);
		offer_beat(sm4_pkg::CMD_KEY_WRITE, set, idx, kval, {$urandom, $urandom},
			{$urandom, $urandom});
	endtask

	task automatic crypt_block(input logic set, input logic [sm4_pkg::HALF_W-1:0] hi,
			input logic [sm4_pkg::HALF_W-1:0] lo);
		offer_beat(sm4_pkg::CMD_CRYPT, set, sm4_pkg::RND_W'($urandom), $urandom, hi, lo);
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (blocks_in_flight != 0) @(negedge clk);
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		src_idle_pct  = idle;
		snk_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 25)
				write_key(1'($urandom_range(1)),
					sm4_pkg::RND_W'($urandom_range(sm4_pkg::ROUNDS - 1)), pick_word());
			else
				crypt_block(1'($urandom_range(1)), {pick_word(), pick_word()},
					{pick_word(), pick_word()});
		end
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		cycle_count    = 0;
		beats_sent     = 0;
		src_idle_pct   = 0;
		snk_stall_pct  = 0;
		cmd.valid      = 1'b0;
		cmd.command    = sm4_pkg::CMD_KEY_WRITE;
		cmd.key_set    = KSET_ENC;
		cmd.key_index  = '0;
		cmd.key_value  = '0;
		cmd.block_high = '0;
		cmd.block_low  = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill both key sets before any block may read them
		for (int s = 0; s < 2; s++)
			for (int r = 0; r < sm4_pkg::ROUNDS; r++)
				write_key(s[0], r[sm4_pkg::RND_W-1:0],
					(r == 0) ? '0 : (r == sm4_pkg::ROUNDS - 1) ? '1 : $urandom);

		crypt_block(KSET_ENC, '0, '0);
		crypt_block(KSET_ENC, '1, '1);
		crypt_block(KSET_DEC, '0, '0);
		crypt_block(KSET_DEC, '1, '1);
		crypt_block(KSET_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
		crypt_block(KSET_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
		crypt_block(KSET_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		crypt_block(KSET_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		crypt_block(KSET_ENC, 64'h8000000000000000, 64'h0000000000000001);
		crypt_block(KSET_DEC, 64'h0000000000000001, 64'h8000000000000000);
		// block fields of a key write are don't-care
		offer_beat(sm4_pkg::CMD_KEY_WRITE, KSET_ENC, 5'd0, '1, '1, '1);
		offer_beat(sm4_pkg::CMD_KEY_WRITE, KSET_DEC, 5'd31, '0, 64'hdeadbeefcafef00d, '1);
		// key fields of a crypt are don't-care
		offer_beat(sm4_pkg::CMD_CRYPT, KSET_ENC, '1, '1, 64'h0123456789abcdef,
			64'hfedcba9876543210);
		offer_beat(sm4_pkg::CMD_CRYPT, KSET_DEC, '0, '0, '1, '0);
		wait_drained();

		random_phase(450, 0, 0);
		random_phase(450, 48, 0);
		random_phase(450, 0, 48);
		random_phase(450, 14, 14);

		repeat (2 * sm4_pkg::ROUNDS + 8) @(negedge clk);
		if (mismatch_count == 0 && blocks_in_flight == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
